### src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int PAGE_IN_W = 16;
    localparam int CFG_W     = 5;
    localparam int FIDX_W    = 4;
    localparam int COUNT_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int FAULT_W   = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    localparam logic REG_FRAMES_IN_USE = 1'b0;

endpackage

### src/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement with least-recently-used tie break.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one page reference per transaction.
//   Output channel: o_valid / i_stall carry hit, frame index and the running
//   fault count, one result transaction per reference.
//   APB port: register frames_in_use at byte address 0; the user must write
//   it only while the block is idle, and the block does not enforce this.
//   Frame data (page, use count, stamp) lives in one memory, one entry per
//   frame, read one entry a cycle; valid bits are flip-flops.
//   A reference is scanned over the N active frames through the frame
//   memory's single read port, then written back; no new reference is
//   accepted until its write-back is done (o_stall is high while busy).
//   Reset: all frames invalid, counters zero, frames_in_use = 16. No clearing
//   pass is needed.
//   Stall: a result waits in the output register; the next reference is
//   accepted and scanned meanwhile, and its write-back holds until the
//   output register is free.
// ----------------------------------------------------------------------------
module lfu_page_replacement #(
    parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lfu_pkg::PAGE_IN_W-1:0] i_page_number,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [lfu_pkg::FIDX_W-1:0]   o_frame_index,
    output logic [lfu_pkg::FAULT_W-1:0]  o_fault_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfu_pkg::APB_AW-1:0]   paddr,
    input  logic [lfu_pkg::APB_DW-1:0]   pwdata,
    output logic [lfu_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int CNTW = lfu_pkg::COUNT_W;
    localparam int STW  = lfu_pkg::STAMP_W;
    localparam int FIW  = lfu_pkg::FIDX_W;
    localparam int CFW  = lfu_pkg::CFG_W;
    localparam int EW   = PAGE_BITS + CNTW + STW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]                  r_state;
    logic [CFW-1:0]              r_cfg;
    logic [MAX_FRAMES-1:0]       r_fvalid;
    logic [STW-1:0]              r_seq;
    logic [lfu_pkg::FAULT_W-1:0] r_faults;
    logic [PAGE_BITS-1:0]        r_page;
    logic [CW-1:0]               r_idx;
    logic                        r_cvalid;
    logic [IW-1:0]               r_cidx;
    logic                        r_hit;
    logic [IW-1:0]               r_hslot;
    logic [CNTW-1:0]             r_hcnt;
    logic                        r_efound;
    logic [IW-1:0]               r_eslot;
    logic [IW-1:0]               r_bslot;
    logic [CNTW-1:0]             r_bcnt;
    logic [STW-1:0]              r_bstamp;

    logic [CW-1:0]               w_n;
    logic                        w_cfg_we;
    logic                        w_accept;
    logic                        w_wb;
    logic [IW-1:0]               w_slot;
    logic [CNTW-1:0]             w_cnt;
    logic [lfu_pkg::FAULT_W-1:0] n_faults;
    logic [EW-1:0]               w_wdata;
    logic [EW-1:0]               w_rdata;
    logic [PAGE_BITS-1:0]        w_rd_page;
    logic [CNTW-1:0]             w_rd_cnt;
    logic [STW-1:0]              w_rd_stamp;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready
                      && (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE);
    assign prdata   = (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE)
                      ? lfu_pkg::APB_DW'(r_cfg) : '0;

    always_comb begin
        if (r_cfg == '0) begin
            w_n = CW'(1);
        end else if (32'(r_cfg) > 32'(MAX_FRAMES)) begin
            w_n = CW'(MAX_FRAMES);
        end else begin
            w_n = CW'(r_cfg);
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_wb     = (r_state == S_WRITE) && (!o_valid || !i_stall);

    assign {w_rd_page, w_rd_cnt, w_rd_stamp} = w_rdata;

    always_comb begin
        if (r_hit) begin
            w_slot = r_hslot;
            w_cnt  = (r_hcnt == lfu_pkg::COUNT_MAX) ? r_hcnt : r_hcnt + CNTW'(1);
        end else begin
            w_slot = r_efound ? r_eslot : r_bslot;
            w_cnt  = '0;
        end
        n_faults = r_faults;
        if (!r_hit && (r_faults != lfu_pkg::FAULT_MAX)) begin
            n_faults = r_faults + lfu_pkg::FAULT_W'(1);
        end
    end

    assign w_wdata = {r_page, w_cnt, r_seq};

    lfu_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FRAMES)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (w_wb),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= lfu_pkg::CFG_RESET;
            r_fvalid <= '0;
            r_seq    <= '0;
            r_faults <= '0;
            r_cvalid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                r_cfg <= pwdata[CFW-1:0];
            end
            if (w_wb) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cvalid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cvalid <= (r_idx < w_n);
                    if ((r_idx == w_n) && r_cvalid) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_cvalid <= 1'b0;
                    if (w_wb) begin
                        r_fvalid[w_slot] <= 1'b1;
                        r_faults         <= n_faults;
                        if (r_seq != lfu_pkg::STAMP_MAX) begin
                            r_seq <= r_seq + STW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= PAGE_BITS'(i_page_number);
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_efound <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (r_idx < w_n) begin
                r_idx <= r_idx + CW'(1);
            end
            r_cidx <= r_idx[IW-1:0];
            if (r_cvalid) begin
                if (r_fvalid[r_cidx] && (w_rd_page == r_page) && !r_hit) begin
                    r_hit   <= 1'b1;
                    r_hslot <= r_cidx;
                    r_hcnt  <= w_rd_cnt;
                end
                if (!r_fvalid[r_cidx] && !r_efound) begin
                    r_efound <= 1'b1;
                    r_eslot  <= r_cidx;
                end
                if ((r_cidx == '0) || (w_rd_cnt < r_bcnt)
                    || ((w_rd_cnt == r_bcnt) && (w_rd_stamp < r_bstamp))) begin
                    r_bslot  <= r_cidx;
                    r_bcnt   <= w_rd_cnt;
                    r_bstamp <= w_rd_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb) begin
            o_hit         <= r_hit;
            o_frame_index <= FIW'(w_slot);
            o_fault_count <= n_faults;
        end
    end

endmodule

### tb/lfu_page_replacement_tb.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement_tb
// Self-checking bench for the LFU page replacement block. A driver feeds page
// references from a backlog, an in-bench predictor of the frame table works
// out hit, frame and fault count for every accepted reference, and a monitor
// compares each result transaction against the oldest prediction. The run
// covers eviction by lower use count, a directed fill and eviction sequence,
// and random traffic over a shared working set under several frame counts,
// including zero, out-of-range values and lowered then raised counts.
// ----------------------------------------------------------------------------
module lfu_page_replacement_tb;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 91;
    localparam int REPEAT_HITS     = 20;

    typedef struct packed {
        logic                        hit;
        logic [lfu_pkg::FIDX_W-1:0]  frame;
        logic [lfu_pkg::FAULT_W-1:0] faults;
    } t_access_outcome;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic                           o_stall;
    logic [lfu_pkg::PAGE_IN_W-1:0]  i_page_number = '0;
    logic                           o_valid;
    logic                           i_stall       = 1'b0;
    logic                           o_hit;
    logic [lfu_pkg::FIDX_W-1:0]     o_frame_index;
    logic [lfu_pkg::FAULT_W-1:0]    o_fault_count;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [lfu_pkg::APB_AW-1:0]     paddr         = '0;
    logic [lfu_pkg::APB_DW-1:0]     pwdata        = '0;
    logic [lfu_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    lfu_page_replacement i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_page_number (i_page_number),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_frame_index (o_frame_index),
        .o_fault_count (o_fault_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // predicted frame table
    logic [lfu_pkg::PAGE_IN_W-1:0] frame_page  [lfu_pkg::MAX_FRAMES_DEF];
    logic                          frame_live  [lfu_pkg::MAX_FRAMES_DEF];
    logic [lfu_pkg::COUNT_W-1:0]   frame_uses  [lfu_pkg::MAX_FRAMES_DEF];
    logic [lfu_pkg::STAMP_W-1:0]   frame_stamp [lfu_pkg::MAX_FRAMES_DEF];
    logic [lfu_pkg::STAMP_W-1:0]   access_seq     = '0;
    logic [lfu_pkg::FAULT_W-1:0]   faults_total   = '0;
    logic [lfu_pkg::CFG_W-1:0]     frames_setting = lfu_pkg::CFG_RESET;

    logic [lfu_pkg::PAGE_IN_W-1:0] page_backlog [$];
    t_access_outcome               predicted_outcomes [$];
    logic [lfu_pkg::PAGE_IN_W-1:0] working_base;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int queued_count       = 0;
    int checked_count      = 0;
    int mismatch_count     = 0;
    int idle_cycles        = 0;

    initial begin
        for (int f = 0; f < lfu_pkg::MAX_FRAMES_DEF; f++) begin
            frame_page[f]  = '0;
            frame_live[f]  = 1'b0;
            frame_uses[f]  = '0;
            frame_stamp[f] = '0;
        end
    end

    function automatic t_access_outcome resolve_reference(
        input logic [lfu_pkg::PAGE_IN_W-1:0] page
    );
        t_access_outcome outcome;
        int              active;
        int              slot;
        bit              is_hit;
        bit              found;
        active = (frames_setting == 0) ? 1 :
                 (frames_setting > lfu_pkg::MAX_FRAMES_DEF) ? lfu_pkg::MAX_FRAMES_DEF :
                 int'(frames_setting);
        slot   = 0;
        is_hit = 1'b0;
        found  = 1'b0;
        for (int f = 0; f < active; f++) begin
            if (!is_hit && frame_live[f] && frame_page[f] == page) begin
                slot   = f;
                is_hit = 1'b1;
            end
        end
        if (is_hit) begin
            if (frame_uses[slot] != lfu_pkg::COUNT_MAX)
                frame_uses[slot] = frame_uses[slot] + 1'b1;
            frame_stamp[slot] = access_seq;
        end else begin
            for (int f = 0; f < active; f++) begin
                if (!found && !frame_live[f]) begin
                    slot  = f;
                    found = 1'b1;
                end
            end
            if (!found) begin
                slot = 0;
                for (int f = 1; f < active; f++) begin
                    if (frame_uses[f] < frame_uses[slot] ||
                        (frame_uses[f] == frame_uses[slot] &&
                         frame_stamp[f] < frame_stamp[slot]))
                        slot = f;
                end
            end
            frame_page[slot]  = page;
            frame_live[slot]  = 1'b1;
            frame_uses[slot]  = '0;
            frame_stamp[slot] = access_seq;
            if (faults_total != lfu_pkg::FAULT_MAX)
                faults_total = faults_total + 1'b1;
        end
        if (access_seq != lfu_pkg::STAMP_MAX)
            access_seq = access_seq + 1'b1;
        outcome.hit    = is_hit;
        outcome.frame  = lfu_pkg::FIDX_W'(slot);
        outcome.faults = faults_total;
        return outcome;
    endfunction

    function automatic logic [lfu_pkg::PAGE_IN_W-1:0] random_page(input int span);
        int                            pick;
        logic [lfu_pkg::PAGE_IN_W-1:0] one_hot;
        pick    = $urandom_range(0, 99);
        one_hot = lfu_pkg::PAGE_IN_W'(1) << $urandom_range(0, lfu_pkg::PAGE_IN_W - 1);
        if (pick < 70)
            return working_base + lfu_pkg::PAGE_IN_W'($urandom_range(0, span - 1));
        if (pick < 90)
            return lfu_pkg::PAGE_IN_W'($urandom);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return one_hot;
            default: return ~one_hot;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h after %0d results",
                 what, got, want, checked_count);
    endtask

    task automatic enqueue_page(input logic [lfu_pkg::PAGE_IN_W-1:0] page);
        page_backlog.push_back(page);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (checked_count != queued_count)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_frames_in_use(input logic [lfu_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lfu_pkg::APB_AW'(4 * lfu_pkg::REG_FRAMES_IN_USE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        frames_setting = value[lfu_pkg::CFG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_page_number <= '0;
        end else begin
            if (i_valid && !o_stall)
                predicted_outcomes.push_back(resolve_reference(i_page_number));
            if (!i_valid || !o_stall) begin
                if (page_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_valid       <= 1'b1;
                    i_page_number <= page_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_access_outcome want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("unexpected result frame", 32'(o_frame_index), '0);
                end else begin
                    want = predicted_outcomes.pop_front();
                    checked_count++;
                    if (o_hit !== want.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                    if (o_frame_index !== want.frame)
                        report_mismatch("frame_index", 32'(o_frame_index), 32'(want.frame));
                    if (o_fault_count !== want.faults)
                        report_mismatch("fault_count", o_fault_count, want.faults);
                end
            end
            i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lfu_page_replacement verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [lfu_pkg::APB_DW-1:0] phase_setting [RANDOM_PHASES];
        int                         span;
        phase_setting = '{32'd1, 32'd0, 32'd31, 32'd17,
                          32'd4, 32'hFFFF_FFE7, 32'd16, 32'd2,
                          32'd8, 32'd3, 32'd12, 32'd16};
        working_base       = lfu_pkg::PAGE_IN_W'($urandom);
        sender_idle_pct    = 22;
        receiver_stall_pct = 69;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // build up one frame's use count, then miss: the other frame must go
        write_frames_in_use(32'd2);
        enqueue_page(16'h0000);
        repeat (6) enqueue_page(16'h0000);
        enqueue_page(16'hFFFF);
        repeat (REPEAT_HITS) enqueue_page(16'hFFFF);
        enqueue_page(16'h8001);
        enqueue_page(16'hFFFF);
        wait_drained();

        write_frames_in_use(32'd16);
        enqueue_page(16'h0000);
        enqueue_page(16'h7FFF);
        enqueue_page(16'hAAAA);
        enqueue_page(16'h5555);
        for (int p = 1; p <= 12; p++)
            enqueue_page(lfu_pkg::PAGE_IN_W'(p));
        enqueue_page(16'h7FFF);
        enqueue_page(16'h7FFF);
        enqueue_page(16'hFFFF);
        enqueue_page(16'h1234);
        enqueue_page(16'h4321);
        enqueue_page(16'h0000);
        enqueue_page(16'h8000);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    sender_idle_pct    = 22;
                    receiver_stall_pct = 69;
                end
                1: begin
                    sender_idle_pct    = 69;
                    receiver_stall_pct = 22;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            write_frames_in_use(phase_setting[ph]);
            span = 4 + $urandom_range(0, 20);
            repeat (PHASE_ITEMS) enqueue_page(random_page(span));
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (predicted_outcomes.size() != 0)
            report_mismatch("results missing", '0, 32'(predicted_outcomes.size()));
        if (mismatch_count == 0) begin
            $display("lfu_page_replacement verification clean");
        end else begin
            $display("lfu_page_replacement verification failed");
        end
        $finish;
    end

endmodule

### sim.f
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_page_replacement.sv
tb/lfu_page_replacement_tb.sv
